### sv/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants for the signed integer to decimal block
// Holds the pipeline payload, character codes and the BCD adjust function.
// ----------------------------------------------------------------------------
package s2d_pkg;

  localparam int VALUE_W         = 32;
  localparam int NUM_DIGITS      = 10;
  localparam int BCD_W           = 4 * NUM_DIGITS;
  localparam int STEPS_PER_STAGE = 8;
  localparam int NUM_BCD_STAGES  = VALUE_W / STEPS_PER_STAGE;
  localparam int IDX_W           = $clog2(NUM_DIGITS);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;

  // Work item moving down the conversion pipeline.
  typedef struct packed {
    logic               neg;
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } s2d_work_t;

  // Add 3 to every BCD digit that is 5 or more, ahead of a shift.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
    logic [BCD_W-1:0] r;
    r = b;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

### sv/s2d_bcd_stage.sv
// ----------------------------------------------------------------------------
// s2d_bcd_stage: one registered slice of the binary to BCD conversion
// Runs STEPS_PER_STAGE shift-and-adjust steps and holds the result.
// ----------------------------------------------------------------------------
module s2d_bcd_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  s2d_pkg::s2d_work_t  in_work,
  output logic                out_valid,
  input  logic                out_ready,
  output s2d_pkg::s2d_work_t  out_work
);
  import s2d_pkg::*;

  s2d_work_t work_next;

  always_comb begin
    logic [BCD_W-1:0]   b;
    logic [VALUE_W-1:0] n;
    b = in_work.bcd;
    n = in_work.bin;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      b = bcd_adjust(b);
      {b, n} = {b[BCD_W-2:0], n, 1'b0};
    end
    work_next.neg = in_work.neg;
    work_next.bcd = b;
    work_next.bin = n;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule

### sv/s2d_emitter.sv
// ----------------------------------------------------------------------------
// s2d_emitter: character serializer
// Loads one converted number and sends its sign and digits one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module s2d_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  s2d_pkg::s2d_work_t  in_work,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tlast
);
  import s2d_pkg::*;

  logic             busy;
  logic             neg_pending;
  logic [IDX_W-1:0] idx;
  logic [3:0]       digits [NUM_DIGITS];
  logic [IDX_W-1:0] lead;
  logic             last_char;
  logic             take;
  logic             load;

  // Highest nonzero digit; zero keeps a single digit.
  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (in_work.bcd[4*i +: 4] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  assign last_char = !neg_pending && (idx == '0);
  assign take      = busy && m_tready;
  assign in_ready  = !busy || (m_tready && last_char);
  assign load      = in_ready && in_valid;

  assign m_tvalid = busy;
  assign m_tlast  = last_char;
  assign m_tdata  = neg_pending ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digits[idx]});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      neg_pending <= 1'b0;
      idx         <= '0;
    end else if (load) begin
      busy        <= 1'b1;
      neg_pending <= in_work.neg;
      idx         <= lead;
    end else if (take) begin
      if (neg_pending) begin
        neg_pending <= 1'b0;
      end else if (idx == '0) begin
        busy <= 1'b0;
      end else begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digits[i] <= in_work.bcd[4*i +: 4];
      end
    end
  end

endmodule

### sv/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Converts each request to a run of characters, most significant first.
// ----------------------------------------------------------------------------
// Each request on the slave side carries one two's complement 32-bit value.
// The block answers with its decimal text on the master side, one ASCII
// character per transfer: a '-' first for negative values, then the digits
// with leading zeros dropped ("0" for zero, "-2147483648" for the most
// negative value). m_tlast marks the final character of each run.
// A request passes an absolute-value stage and four binary to BCD stages of
// eight shift-and-adjust steps each, all registered, before the character
// serializer offers its first character. The pipeline can take a request
// every cycle while not stalled, but the serializer sends one character per
// cycle while m_tready is high, so it sets the sustained rate by text length,
// 1 to 11 characters. Back-pressure on m_tready stalls the whole pipeline
// without loss. Nothing is kept from one request to the next.
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] char_code
  output logic        m_tlast    // last
);
  import s2d_pkg::*;

  // Entry stage: take the magnitude, hold the sign.
  logic       entry_valid;
  s2d_work_t  entry_work;

  // Pipeline links: link 0 is the entry stage output.
  logic       link_valid [NUM_BCD_STAGES+1];
  logic       link_ready [NUM_BCD_STAGES+1];
  s2d_work_t  link_work  [NUM_BCD_STAGES+1];

  assign s_tready = !entry_valid || link_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (s_tready) begin
      entry_valid <= s_tvalid;
    end
  end

  // Negate in 32 bits so the most negative value gives 2147483648.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      entry_work.neg <= s_tdata[VALUE_W-1];
      entry_work.bcd <= '0;
      entry_work.bin <= s_tdata[VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
    end
  end

  assign link_valid[0] = entry_valid;
  assign link_work[0]  = entry_work;

  // Binary to BCD, a slice of steps per registered stage.
  for (genvar g = 0; g < NUM_BCD_STAGES; g++) begin : g_bcd
    s2d_bcd_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[g]),
      .in_ready  (link_ready[g]),
      .in_work   (link_work[g]),
      .out_valid (link_valid[g+1]),
      .out_ready (link_ready[g+1]),
      .out_work  (link_work[g+1])
    );
  end

  // Serialize sign and digits onto the master side.
  s2d_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .in_valid (link_valid[NUM_BCD_STAGES]),
    .in_ready (link_ready[NUM_BCD_STAGES]),
    .in_work  (link_work[NUM_BCD_STAGES]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### tb/signed_int_to_decimal_ascii_test.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test: self-checking bench for the decimal text
// Sends signed 32-bit values and checks every character that comes back
// against decimal text worked out in the bench, under varied flow control.
// ----------------------------------------------------------------------------
// Each accepted request is turned into the characters it must produce: an
// optional '-' and then the digits with no leading zeros, the last one
// flagged. Characters leaving the block are checked in order against that
// list. The run first sends corner values, then random values grouped by
// digit count, in phases with different amounts of sender idling and
// receiver stalling. One phase holds m_tready low for a long stretch so that
// the pipeline fills and stalls its input.
module signed_int_to_decimal_ascii_test;
  timeunit 1ns;
  timeprecision 1ps;

  import s2d_pkg::CHAR_MINUS;
  import s2d_pkg::CHAR_ZERO;

  localparam int BATCH_SIZE    = 105;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRESSURE_REQS = 30;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // Holds the characters still owed by the block, oldest first.
  class ascii_text_board;
    text_char_t owed_chars[$];
    int         errors = 0;

    // Render one accepted value as decimal text and queue its characters.
    function void note_value(logic [31:0] value);
      logic [31:0] mag;
      logic [3:0]  digits [10];
      int          ndig;
      mag  = value[31] ? 32'd0 - value : value;
      ndig = 0;
      do begin
        digits[ndig] = 4'(mag % 32'd10);
        mag = mag / 32'd10;
        ndig++;
      end while (mag != 0 && ndig < 10);
      if (value[31]) begin
        owed_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
      end
      for (int d = ndig - 1; d >= 0; d--) begin
        owed_chars.push_back('{code: CHAR_ZERO + 8'(digits[d]), last: (d == 0)});
      end
    endfunction

    function void check_char(logic [7:0] code, logic last);
      text_char_t want;
      if (owed_chars.size() == 0) begin
        $error("unexpected character: char_code %0d last %0b", code, last);
        errors++;
        return;
      end
      want = owed_chars.pop_front();
      if (code !== want.code) begin
        $error("char_code mismatch: expected %0d, actual %0d", want.code, code);
        errors++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] value
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] char_code
  logic        m_tlast;   // last

  ascii_text_board board = new();

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  int cycles        = 0;

  signed_int_to_decimal_ascii dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up on a hung run; the limit is far above the slowest correct run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check every character handed over at a rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_char(m_tdata, m_tlast);
    end
  end

  // Offer one request, idling first at random, and wait until it is taken.
  // tvalid stays high into the next call so back-to-back requests have no gap.
  task automatic send_value(logic [31:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    board.note_value(value);
  endtask

  // Random values: mostly drawn by digit count so short and long texts both
  // show up often, the rest raw 32-bit patterns.
  task automatic send_random_batch(int count);
    longint lo;
    longint hi;
    longint mag;
    int     ndig;
    repeat (count) begin
      if ($urandom_range(9) < 2) begin
        send_value($urandom);
      end else begin
        ndig = $urandom_range(1, 10);
        lo = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'd2147483648) hi = 64'd2147483648;
        mag = lo + longint'($urandom) % (hi - lo + 1);
        // the magnitude 2^31 only exists on the negative side
        if ($urandom_range(1) == 1 || mag == 64'd2147483648) begin
          send_value(32'(-mag));
        end else begin
          send_value(32'(mag));
        end
      end
    end
  endtask

  // Drop valid and pause until every owed character has come back.
  task automatic drain_text();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] corner_values [22];
    corner_values = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
      32'd100, -32'sd100, 32'd12345, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h8000_0001, 32'd1000000000, -32'sd1000000000, 32'd999999999,
      32'd1000000009, 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, 32'd1234567890
    };
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no idling: corner values, then random
    foreach (corner_values[i]) send_value(corner_values[i]);
    send_random_batch(BATCH_SIZE);
    drain_text();

    // sender mostly idle
    send_idle_pct = 76;
    send_random_batch(BATCH_SIZE);
    drain_text();

    // receiver mostly stalled
    send_idle_pct = 0;
    stall_pct     = 76;
    send_random_batch(BATCH_SIZE);
    drain_text();

    // both sides idle at random
    send_idle_pct = 37;
    stall_pct     = 37;
    send_random_batch(BATCH_SIZE);
    drain_text();

    // long receiver hold while requests keep coming, filling the pipeline
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    send_random_batch(PRESSURE_REQS);
    drain_text();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d characters never arrived", board.pending());
    end
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
